// ===== src/gef_pkg.sv =====
// Package for the groundwater edge-flow block: commands, sequencer states,
// element record layout and datapath widths.
// Used by groundwater_edge_flow_top; depends on nothing.
`default_nettype none

package gef_pkg;

    // Default table depth and the reset value of the timestep ceiling
    localparam int unsigned ELEMENT_COUNT_DEFAULT = 1024;
    localparam logic [47:0] CEILING_RESET         = 48'd235929600;

    // Datapath widths: wide accumulator, narrow operand and remainder
    localparam int unsigned WIDE_W   = 192;
    localparam int unsigned NARROW_W = 96;
    localparam int unsigned DIST_W   = 42;
    localparam int unsigned CNT_W    = 8;

    // Step counts of the iterative units
    localparam logic [CNT_W-1:0] SQRT_STEPS = 8'd42;
    localparam logic [CNT_W-1:0] DIV_STEPS  = 8'd192;

    // Commands carried by an input transaction
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_FLOW    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    typedef struct packed {
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic signed [39:0] surface;
        logic signed [39:0] bedrock;
        logic        [39:0] area;
        logic        [35:0] cond;
        logic        [15:0] por;
        logic signed [39:0] head;
    } elem_rec_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_A,
        ST_LD_B,
        ST_PREP,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_KH,
        ST_DL,
        ST_NUM,
        ST_DIVF,
        ST_PA,
        ST_DTMUL,
        ST_DIVT,
        ST_OUT
    } gef_state_t;

endpackage

`default_nettype wire

// ===== src/groundwater_edge_flow_top.sv =====
// Top level of the groundwater edge-flow block: element table memory,
// sequencer and shared shift-add / shift-subtract datapath.
// Depends on gef_pkg.
`default_nettype none

// Groundwater edge flow. Command 0 writes one element record into a table of
// ELEMENT_COUNT entries, command 2 restarts the running minimum timestep to the
// ceiling register, command 1 computes the flow across the edge between two
// elements and lowers the running minimum. Every transaction returns exactly
// one result. Write, restart and unused commands, and compute commands with an
// index out of range, go from acceptance straight to the output state. A
// compute command reads both records from the single table port, then runs on
// one shared datapath that does one step per cycle: two squarings and up to
// five further products by shift-add (stepping through the multiplier up to
// its highest set bit), a 42-step square root and up to two 192-step
// divisions. A coincident or dry edge ends after the preparation step without
// using the datapath. One transaction is handled at a time; the next is
// accepted once the result is in the output register. The table has no reset
// and no clearing pass; reading an element never written gives undefined
// results.
module groundwater_edge_flow_top
    import gef_pkg::*;
#(
    parameter int unsigned ELEMENT_COUNT = ELEMENT_COUNT_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [47:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         command,
    input  wire logic [9:0]         first_index,
    input  wire logic [9:0]         second_index,
    input  wire logic [39:0]        edge_length,
    input  wire logic signed [39:0] center_x,
    input  wire logic signed [39:0] center_y,
    input  wire logic signed [39:0] surface_elevation,
    input  wire logic signed [39:0] bedrock_elevation,
    input  wire logic [39:0]        cell_area,
    input  wire logic [35:0]        hydraulic_conductivity,
    input  wire logic [15:0]        pore_fraction,
    input  wire logic signed [39:0] water_head,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [63:0]      flow_rate,
    output logic [47:0]             min_timestep,
    output logic                    status
);

    localparam int unsigned AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

    // Element table
    elem_rec_t mem [ELEMENT_COUNT];
    elem_rec_t rdata_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    elem_rec_t     wr_rec;

    // Control and item registers
    gef_state_t state_reg, state_next;
    logic [47:0] ceiling_reg;
    logic [47:0] running_reg, running_next;
    logic [9:0]  b_idx_reg, b_idx_next;
    logic [39:0] len_reg, len_next;
    elem_rec_t   rec_a_reg, rec_a_next;
    elem_rec_t   rec_b_reg, rec_b_next;

    // Prepared operands
    logic [40:0] ay_reg, ay_next;
    logic [36:0] ks_reg, ks_next;
    logic [40:0] hs_reg, hs_next;
    logic [39:0] dh_reg, dh_next;
    logic [16:0] ps_reg, ps_next;
    logic [40:0] as_reg, as_next;
    logic        neg_reg, neg_next;

    // Shared datapath
    logic [WIDE_W-1:0]   ma_reg, ma_next;
    logic [WIDE_W-1:0]   acc_reg, acc_next;
    logic [NARROW_W-1:0] mb_reg, mb_next;
    logic [NARROW_W-1:0] rem_reg, rem_next;
    logic [NARROW_W-1:0] t1_reg, t1_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // Result staging and output registers
    logic [63:0] res_flow_reg, res_flow_next;
    logic        res_status_reg, res_status_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] flow_out_reg, flow_out_next;
    logic [47:0] min_out_reg, min_out_next;
    logic        status_out_reg, status_out_next;

    // Step helpers
    logic                mul_done;
    logic [WIDE_W-1:0]   mul_acc;
    logic [NARROW_W-1:0] div_rem;
    logic                div_ge;
    logic [NARROW_W-1:0] sq_rem;
    logic [NARROW_W-1:0] sq_trial;
    logic                sq_ge;

    // Prep helpers
    logic signed [40:0] dx, dy, dhead;
    logic [40:0]        ax, ay;
    logic signed [39:0] m_a, m_b;
    logic signed [40:0] hraw_a, hraw_b;
    logic [39:0]        h_a, h_b;
    logic               a_high, b_high, go;

    // Quotient tail and saturation
    logic [WIDE_W-43:0] qf;
    logic [63:0]        mag;
    logic [47:0]        dt;

    logic accept;
    logic a_ok, b_ok;

    assign accept = in_valid && !in_stall;
    assign a_ok = {22'd0, first_index} < 32'(ELEMENT_COUNT);
    assign b_ok = {22'd0, second_index} < 32'(ELEMENT_COUNT);

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign flow_rate    = signed'(flow_out_reg);
    assign min_timestep = min_out_reg;
    assign status       = status_out_reg;

    assign wr_rec = '{x: center_x, y: center_y, surface: surface_elevation,
                      bedrock: bedrock_elevation, area: cell_area,
                      cond: hydraulic_conductivity, por: pore_fraction,
                      head: water_head};
    assign mem_we  = accept && (command == CMD_WRITE) && a_ok;
    assign rd_addr = (state_reg == ST_LD_A) ? AW'(b_idx_reg) : AW'(first_index);

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(first_index)] <= wr_rec;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Shared step logic
    assign mul_done = (mb_reg == '0);
    assign mul_acc  = mb_reg[0] ? acc_reg + ma_reg : acc_reg;
    assign div_rem  = {rem_reg[NARROW_W-2:0], ma_reg[WIDE_W-1]};
    assign div_ge   = (div_rem >= mb_reg);
    assign sq_rem   = {rem_reg[NARROW_W-3:0], ma_reg[WIDE_W-1:WIDE_W-2]};
    assign sq_trial = NARROW_W'({dist_reg, 2'b01});
    assign sq_ge    = (sq_rem >= sq_trial);

    // Edge geometry and water heights from the two records
    always_comb
    begin
        dx = 41'(rec_a_reg.x) - 41'(rec_b_reg.x);
        dy = 41'(rec_a_reg.y) - 41'(rec_b_reg.y);
        ax = dx[40] ? 41'(-dx) : 41'(dx);
        ay = dy[40] ? 41'(-dy) : 41'(dy);
        dhead = 41'(rec_a_reg.head) - 41'(rec_b_reg.head);
        a_high = (rec_a_reg.head > rec_b_reg.head);
        b_high = (rec_a_reg.head < rec_b_reg.head);
        m_a = (rec_a_reg.head < rec_a_reg.surface) ? rec_a_reg.head : rec_a_reg.surface;
        m_b = (rec_b_reg.head < rec_b_reg.surface) ? rec_b_reg.head : rec_b_reg.surface;
        hraw_a = 41'(m_a) - 41'(rec_a_reg.bedrock);
        hraw_b = 41'(m_b) - 41'(rec_b_reg.bedrock);
        h_a = hraw_a[40] ? 40'd0 : hraw_a[39:0];
        h_b = hraw_b[40] ? 40'd0 : hraw_b[39:0];
        go = (a_high && (h_a != '0)) || (b_high && (h_b != '0));
    end

    // Scale and saturate the quotients
    always_comb
    begin
        qf = ma_reg[WIDE_W-1:42];
        if (!neg_reg)
        begin
            mag = (|qf[WIDE_W-43:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, qf[62:0]};
        end
        else
        begin
            mag = ((|qf[WIDE_W-43:64]) || (qf[63] && (|qf[62:0])))
                ? 64'h8000_0000_0000_0000 : qf[63:0];
        end
        dt = (|ma_reg[WIDE_W-1:48]) ? 48'hFFFF_FFFF_FFFF : ma_reg[47:0];
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        running_next    = running_reg;
        b_idx_next      = b_idx_reg;
        len_next        = len_reg;
        rec_a_next      = rec_a_reg;
        rec_b_next      = rec_b_reg;
        ay_next         = ay_reg;
        ks_next         = ks_reg;
        hs_next         = hs_reg;
        dh_next         = dh_reg;
        ps_next         = ps_reg;
        as_next         = as_reg;
        neg_next        = neg_reg;
        ma_next         = ma_reg;
        acc_next        = acc_reg;
        mb_next         = mb_reg;
        rem_next        = rem_reg;
        t1_next         = t1_reg;
        dist_next       = dist_reg;
        cnt_next        = cnt_reg;
        res_flow_next   = res_flow_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        flow_out_next   = flow_out_reg;
        min_out_next    = min_out_reg;
        status_out_next = status_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_flow_next   = '0;
                    res_status_next = 1'b0;
                    b_idx_next      = second_index;
                    len_next        = edge_length;
                    state_next      = ST_OUT;
                    if (command == CMD_RESTART)
                    begin
                        running_next = ceiling_reg;
                    end
                    else if ((command == CMD_FLOW) && a_ok && b_ok)
                    begin
                        state_next = ST_LD_A;
                    end
                end
            end
            ST_LD_A:
            begin
                rec_a_next = rdata_reg;
                state_next = ST_LD_B;
            end
            ST_LD_B:
            begin
                rec_b_next = rdata_reg;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                ay_next  = ay;
                ks_next  = 37'(rec_a_reg.cond) + 37'(rec_b_reg.cond);
                hs_next  = 41'(h_a) + 41'(h_b);
                dh_next  = dhead[40] ? 40'(-dhead) : dhead[39:0];
                ps_next  = 17'(rec_a_reg.por) + 17'(rec_b_reg.por);
                as_next  = 41'(rec_a_reg.area) + 41'(rec_b_reg.area);
                neg_next = b_high;
                ma_next  = WIDE_W'(ax);
                mb_next  = NARROW_W'(ax);
                acc_next = '0;
                if ((ax == '0) && (ay == '0))
                begin
                    res_status_next = 1'b1;
                    state_next      = ST_OUT;
                end
                else if (!go)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX, ST_SQY, ST_KH, ST_DL, ST_NUM, ST_PA, ST_DTMUL:
            begin
                if (!mul_done)
                begin
                    // Advance the shift-add multiply by one bit
                    acc_next = mul_acc;
                    ma_next  = {ma_reg[WIDE_W-2:0], 1'b0};
                    mb_next  = {1'b0, mb_reg[NARROW_W-1:1]};
                end
                else
                begin
                    case (state_reg)
                        ST_SQX:
                        begin
                            // Accumulate the y square onto the x square
                            ma_next    = WIDE_W'(ay_reg);
                            mb_next    = NARROW_W'(ay_reg);
                            state_next = ST_SQY;
                        end
                        ST_SQY:
                        begin
                            ma_next    = {acc_reg[83:0], (WIDE_W-84)'(0)};
                            rem_next   = '0;
                            dist_next  = '0;
                            cnt_next   = SQRT_STEPS;
                            state_next = ST_SQRT;
                        end
                        ST_KH:
                        begin
                            t1_next    = acc_reg[NARROW_W-1:0];
                            ma_next    = WIDE_W'(dh_reg);
                            mb_next    = NARROW_W'(len_reg);
                            acc_next   = '0;
                            state_next = ST_DL;
                        end
                        ST_DL:
                        begin
                            ma_next    = WIDE_W'(t1_reg);
                            mb_next    = acc_reg[NARROW_W-1:0];
                            acc_next   = '0;
                            state_next = ST_NUM;
                        end
                        ST_NUM:
                        begin
                            ma_next    = acc_reg;
                            mb_next    = NARROW_W'(dist_reg);
                            rem_next   = '0;
                            cnt_next   = DIV_STEPS;
                            state_next = ST_DIVF;
                        end
                        ST_PA:
                        begin
                            t1_next    = acc_reg[NARROW_W-1:0];
                            ma_next    = WIDE_W'({ks_reg, 2'b00}) + WIDE_W'(ks_reg);
                            mb_next    = NARROW_W'(dh_reg);
                            acc_next   = '0;
                            state_next = ST_DTMUL;
                        end
                        default:
                        begin
                            ma_next    = WIDE_W'({t1_reg, 48'd0});
                            mb_next    = acc_reg[NARROW_W-1:0];
                            rem_next   = '0;
                            cnt_next   = DIV_STEPS;
                            state_next = ST_DIVT;
                        end
                    endcase
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg != '0)
                begin
                    // One root digit per cycle
                    rem_next  = sq_ge ? sq_rem - sq_trial : sq_rem;
                    dist_next = {dist_reg[DIST_W-2:0], sq_ge};
                    ma_next   = {ma_reg[WIDE_W-3:0], 2'b00};
                    cnt_next  = cnt_reg - 1'b1;
                end
                else
                begin
                    ma_next    = WIDE_W'(ks_reg);
                    mb_next    = NARROW_W'(hs_reg);
                    acc_next   = '0;
                    state_next = ST_KH;
                end
            end
            ST_DIVF, ST_DIVT:
            begin
                if (cnt_reg != '0)
                begin
                    // One quotient bit per cycle
                    rem_next = div_ge ? div_rem - mb_reg : div_rem;
                    ma_next  = {ma_reg[WIDE_W-2:0], div_ge};
                    cnt_next = cnt_reg - 1'b1;
                end
                else if (state_reg == ST_DIVF)
                begin
                    res_flow_next = neg_reg ? 64'd0 - mag : mag;
                    if (ks_reg == '0)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        ma_next    = WIDE_W'(ps_reg);
                        mb_next    = NARROW_W'(as_reg);
                        acc_next   = '0;
                        state_next = ST_PA;
                    end
                end
                else
                begin
                    if (dt < running_reg)
                    begin
                        running_next = dt;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    flow_out_next   = res_flow_reg;
                    min_out_next    = running_reg;
                    status_out_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ceiling_reg   <= CEILING_RESET;
            running_reg   <= CEILING_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                ceiling_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        b_idx_reg      <= b_idx_next;
        len_reg        <= len_next;
        rec_a_reg      <= rec_a_next;
        rec_b_reg      <= rec_b_next;
        ay_reg         <= ay_next;
        ks_reg         <= ks_next;
        hs_reg         <= hs_next;
        dh_reg         <= dh_next;
        ps_reg         <= ps_next;
        as_reg         <= as_next;
        neg_reg        <= neg_next;
        ma_reg         <= ma_next;
        acc_reg        <= acc_next;
        mb_reg         <= mb_next;
        rem_reg        <= rem_next;
        t1_reg         <= t1_next;
        dist_reg       <= dist_next;
        cnt_reg        <= cnt_next;
        res_flow_reg   <= res_flow_next;
        res_status_reg <= res_status_next;
        flow_out_reg   <= flow_out_next;
        min_out_reg    <= min_out_next;
        status_out_reg <= status_out_next;
    end

endmodule

`default_nettype wire

// ===== dv/tb_groundwater_edge_flow_top.sv =====
// Testbench for groundwater_edge_flow_top: element writes, edge-flow computes and
// timestep restarts, checked against a built-in fixed-point flow predictor.
// Depends on gef_pkg and the groundwater_edge_flow_top RTL.
`default_nettype none

module tb_groundwater_edge_flow_top;
    import gef_pkg::*;

    localparam int unsigned ELEMS     = 1024;
    localparam int unsigned RUN_LIMIT = 4000000;
    localparam logic [1:0]  CMD_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [9:0]  ia;
        logic [9:0]  ib;
        logic [39:0] len;
        logic [39:0] cx;
        logic [39:0] cy;
        logic [39:0] surf;
        logic [39:0] bed;
        logic [39:0] area;
        logic [35:0] cond;
        logic [15:0] por;
        logic [39:0] head;
    } txn_t;

    typedef struct {
        logic [63:0] flow;
        logic [47:0] dt;
        logic        status;
    } flow_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [47:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    txn_t        drv;
    logic        out_valid;
    logic        out_stall;
    logic signed [63:0] flow_rate;
    logic [47:0] min_timestep;
    logic        status;

    // Predictor state: element table, running minimum and ceiling
    logic [39:0] el_x [ELEMS];
    logic [39:0] el_y [ELEMS];
    logic [39:0] el_surf [ELEMS];
    logic [39:0] el_bed [ELEMS];
    logic [39:0] el_area [ELEMS];
    logic [35:0] el_cond [ELEMS];
    logic [15:0] el_por [ELEMS];
    logic [39:0] el_head [ELEMS];
    logic [47:0] min_dt_model;
    logic [47:0] ceiling_model;

    // Stimulus-side bookkeeping of which elements hold a record
    logic [39:0] gen_x [ELEMS];
    logic [39:0] gen_y [ELEMS];
    bit          gen_written [ELEMS];
    int          written_q[$];

    txn_t        txn_pending_q[$];
    flow_res_t   flow_expect_q[$];
    txn_t        cur;
    int          gap_cnt;
    int          stall_cnt;
    int          hold_cnt;
    bit          held_once;
    bit          quiet;
    int          n_results;
    int          n_flows;
    int          n_mismatch;
    int          cycles;

    groundwater_edge_flow_top u_dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_we                 (cfg_we),
        .cfg_data               (cfg_data),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .command                (drv.cmd),
        .first_index            (drv.ia),
        .second_index           (drv.ib),
        .edge_length            (drv.len),
        .center_x               (drv.cx),
        .center_y               (drv.cy),
        .surface_elevation      (drv.surf),
        .bedrock_elevation      (drv.bed),
        .cell_area              (drv.area),
        .hydraulic_conductivity (drv.cond),
        .pore_fraction          (drv.por),
        .water_head             (drv.head),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .flow_rate              (flow_rate),
        .min_timestep           (min_timestep),
        .status                 (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sext40(logic [39:0] v);
        return {{24{v[39]}}, v};
    endfunction

    // Water column: head clipped to the surface, above bedrock, never negative
    function automatic longint wet_height(int i);
        longint hd;
        longint sf;
        longint h;
        hd = sext40(el_head[i]);
        sf = sext40(el_surf[i]);
        h = ((hd < sf) ? hd : sf) - sext40(el_bed[i]);
        return (h < 0) ? 0 : h;
    endfunction

    // Advance the predicted element table and running minimum by one transaction
    task automatic flow_model_step(input txn_t t, output flow_res_t r);
        longint      dx;
        longint      dy;
        longint      ha;
        longint      hb;
        longint      h1;
        longint      h2;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] root;
        logic [63:0] cand;
        logic [63:0] mag;
        logic [191:0] s2;
        logic [191:0] ks;
        logic [191:0] dh;
        logic [191:0] q;
        logic [191:0] dq;
        int a;
        int b;
        r.flow = '0;
        r.status = 1'b0;
        a = t.ia;
        b = t.ib;
        if (t.cmd == CMD_WRITE)
        begin
            el_x[a] = t.cx;
            el_y[a] = t.cy;
            el_surf[a] = t.surf;
            el_bed[a] = t.bed;
            el_area[a] = t.area;
            el_cond[a] = t.cond;
            el_por[a] = t.por;
            el_head[a] = t.head;
        end
        else if (t.cmd == CMD_RESTART)
        begin
            min_dt_model = ceiling_model;
        end
        else if (t.cmd == CMD_FLOW)
        begin
            dx = sext40(el_x[a]) - sext40(el_x[b]);
            dy = sext40(el_y[a]) - sext40(el_y[b]);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            s2 = 192'(ax) * 192'(ax) + 192'(ay) * 192'(ay);
            if (s2 == 0)
            begin
                r.status = 1'b1;
            end
            else
            begin
                ha = sext40(el_head[a]);
                hb = sext40(el_head[b]);
                h1 = wet_height(a);
                h2 = wet_height(b);
                if ((ha > hb && h1 > 0) || (ha < hb && h2 > 0))
                begin
                    // integer square root of the squared centre distance
                    root = '0;
                    for (int k = 41; k >= 0; k--)
                    begin
                        cand = root | (64'd1 << k);
                        if (192'(cand) * 192'(cand) <= s2)
                            root = cand;
                    end
                    dh = (ha > hb) ? 192'(ha - hb) : 192'(hb - ha);
                    ks = 192'(el_cond[a]) + 192'(el_cond[b]);
                    q = (ks * 192'(h1 + h2) * dh * 192'(t.len)) / 192'(root);
                    q = q >> 42;
                    if (ha > hb)
                    begin
                        mag = (q > 192'(64'h7FFF_FFFF_FFFF_FFFF))
                              ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
                        r.flow = mag;
                    end
                    else
                    begin
                        mag = (q > 192'(64'h8000_0000_0000_0000))
                              ? 64'h8000_0000_0000_0000 : q[63:0];
                        r.flow = 64'd0 - mag;
                    end
                    // Courant limit; infinite when nothing conducts
                    if (ks != 0)
                    begin
                        dq = ((192'(el_por[a]) + 192'(el_por[b]))
                              * (192'(el_area[a]) + 192'(el_area[b])) << 48)
                             / (192'd5 * ks * dh);
                        if (dq > 192'(48'hFFFF_FFFF_FFFF))
                            dq = 192'(48'hFFFF_FFFF_FFFF);
                        if (dq[47:0] < min_dt_model)
                            min_dt_model = dq[47:0];
                    end
                end
            end
        end
        r.dt = min_dt_model;
    endtask

    function automatic logic [39:0] rnd40();
        return 40'({$urandom(), $urandom()});
    endfunction

    function automatic logic [39:0] rnd_span(int lo, int hi);
        return 40'(longint'($urandom_range(0, hi - lo)) + lo) << 16;
    endfunction

    // Random fields everywhere, including the indices; the command comes from the caller
    function automatic txn_t noise_txn(logic [1:0] cmd);
        txn_t t;
        t.cmd = cmd;
        t.ia = 10'($urandom_range(0, ELEMS - 1));
        t.ib = 10'($urandom_range(0, ELEMS - 1));
        t.len = rnd40();
        t.cx = rnd40();
        t.cy = rnd40();
        t.surf = rnd40();
        t.bed = rnd40();
        t.area = rnd40();
        t.cond = 36'({$urandom(), $urandom()});
        t.por = 16'($urandom());
        t.head = rnd40();
        return t;
    endfunction

    // Queue a record write and note the element as valid to read
    task automatic push_write(input txn_t t);
        t.cmd = CMD_WRITE;
        txn_pending_q.push_back(t);
        gen_x[t.ia] = t.cx;
        gen_y[t.ia] = t.cy;
        if (!gen_written[t.ia])
        begin
            gen_written[t.ia] = 1'b1;
            written_q.push_back(t.ia);
        end
    endtask

    // Mostly a plausible element: wet or dry column, nearby centres, sometimes coincident; otherwise noise
    task automatic push_random_write(input int idx);
        txn_t t;
        int   other;
        t = noise_txn(CMD_WRITE);
        t.ia = 10'(idx);
        if ($urandom_range(0, 3) != 0)
        begin
            t.cx = rnd_span(-5000, 5000) + 40'($urandom_range(0, 65535));
            t.cy = rnd_span(-5000, 5000) + 40'($urandom_range(0, 65535));
            t.bed = rnd_span(-200, 200);
            t.surf = t.bed + rnd_span(0, 50);
            t.head = t.bed + rnd_span(-10, 60) + 40'($urandom_range(0, 65535));
            t.cond = 36'($urandom_range(0, 1 << 30));
            t.area = 40'($urandom_range(1, 1 << 30)) << $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0 && written_q.size() > 0)
            begin
                other = written_q[$urandom_range(0, written_q.size() - 1)];
                t.cx = gen_x[other];
                t.cy = gen_y[other];
            end
        end
        push_write(t);
    endtask

    task automatic push_cmd(input logic [1:0] cmd, input int a, input int b,
                            input logic [39:0] len);
        txn_t t;
        t = noise_txn(cmd);
        t.ia = 10'(a);
        t.ib = 10'(b);
        t.len = len;
        txn_pending_q.push_back(t);
    endtask

    // Mostly edge computes between written elements, with writes, restarts and unused commands mixed in
    task automatic push_random_mix(input int count);
        int pick;
        int a;
        int b;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            a = written_q[$urandom_range(0, written_q.size() - 1)];
            b = written_q[$urandom_range(0, written_q.size() - 1)];
            if (pick < 18)
                push_random_write($urandom_range(0, ELEMS - 1));
            else if (pick < 23)
                push_cmd(CMD_RESTART, a, b, rnd40());
            else if (pick < 26)
                push_cmd(CMD_SPARE, a, b, rnd40());
            else if (pick < 34)
                push_cmd(CMD_FLOW, a, b, rnd40());
            else
                push_cmd(CMD_FLOW, a, b, rnd_span(0, 300) + 40'($urandom_range(0, 65535)));
        end
    endtask

    task automatic wait_drained();
        while (txn_pending_q.size() > 0 || flow_expect_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_ceiling(input logic [47:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        ceiling_model = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender: hold a stalled transaction, otherwise idle or offer the next one
    always @(posedge clk)
    begin
        flow_res_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                flow_model_step(cur, r);
                flow_expect_q.push_back(r);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt--;
                    in_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    gap_cnt = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end
                else if (txn_pending_q.size() > 0)
                begin
                    cur = txn_pending_q.pop_front();
                    drv <= cur;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: one long hold-off mid-run, otherwise short random stall bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= (hold_cnt != 0);
            end
            else if (!held_once && n_results >= 150)
            begin
                held_once = 1'b1;
                hold_cnt = 3000;
                out_stall <= 1'b1;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_cnt = $urandom_range(0, 8);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        flow_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (flow_expect_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: flow %0d dt %0d status %0d",
                             flow_rate, min_timestep, status);
            end
            else
            begin
                e = flow_expect_q.pop_front();
                if (e.flow != 0)
                    n_flows++;
                if (flow_rate !== e.flow || min_timestep !== e.dt || status !== e.status)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch #%0d: exp flow %0d dt %0d st %0d, got %0d %0d %0d",
                                 n_results, $signed(e.flow), e.dt, e.status,
                                 flow_rate, min_timestep, status);
                end
            end
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= RUN_LIMIT)
        begin
            $display("timeout with %0d predictions outstanding", flow_expect_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        txn_t t;
        logic [47:0] ceilings [4];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        drv = noise_txn(CMD_SPARE);
        gap_cnt = 0;
        stall_cnt = 0;
        hold_cnt = 0;
        held_once = 1'b0;
        quiet = 1'b0;
        n_results = 0;
        n_flows = 0;
        n_mismatch = 0;
        cycles = 0;
        ceiling_model = CEILING_RESET;
        min_dt_model = CEILING_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed records: extremes, coincident centres, equal heads, tiny distance
        t = noise_txn(CMD_WRITE);
        t.ia = 10'd0; t.cx = '0; t.cy = '0;
        t.surf = 40'h7F_FFFF_FFFF; t.bed = 40'h80_0000_0000; t.head = 40'h7F_FFFF_FFFF;
        t.area = '1; t.cond = '1; t.por = '1;
        push_write(t);
        t = noise_txn(CMD_WRITE);
        t.ia = 10'd1; t.cx = '0; t.cy = '0;
        push_write(t);
        t = noise_txn(CMD_WRITE);
        t.ia = 10'd2; t.cx = 40'd1 << 16; t.cy = '0;
        t.surf = 40'h7F_FFFF_FFFF; t.bed = 40'h80_0000_0000; t.head = 40'h7F_FFFF_FFFF;
        push_write(t);
        t = noise_txn(CMD_WRITE);
        t.ia = 10'd3; t.cx = 40'd1; t.cy = '0;
        t.surf = 40'h7F_FFFF_FFFF; t.bed = 40'h80_0000_0000; t.head = '0;
        t.cond = '0; t.por = '0; t.area = '0;
        push_write(t);
        t = noise_txn(CMD_WRITE);
        t.ia = 10'd4; t.cx = 40'd5 << 16; t.cy = 40'd7 << 16;
        t.surf = 40'd10 << 16; t.bed = '0; t.head = 40'd1 << 16; t.cond = '0;
        push_write(t);
        t = noise_txn(CMD_WRITE);
        t.ia = 10'd5; t.cx = -(40'd3 << 16); t.cy = 40'd4 << 16;
        t.surf = 40'd10 << 16; t.bed = -(40'd5 << 16); t.head = '0;
        t.cond = 36'd1000; t.area = 40'd100 << 8; t.por = 16'd16384;
        push_write(t);
        t = noise_txn(CMD_WRITE);
        t.ia = 10'd6; t.cx = 40'd9 << 16; t.cy = 40'd9 << 16;
        t.surf = 40'd20 << 16; t.bed = 40'd30 << 16; t.head = 40'd10 << 16;
        push_write(t);
        t = noise_txn(CMD_WRITE);
        t.ia = 10'(ELEMS - 1); t.cx = 40'h7F_FFFF_FFFF; t.cy = 40'h80_0000_0000;
        t.surf = '0; t.bed = -(40'd1 << 20); t.head = 40'h80_0000_0000; t.cond = '1;
        push_write(t);

        push_cmd(CMD_FLOW, 0, 1, rnd40());
        push_cmd(CMD_FLOW, 0, 2, rnd40());
        push_cmd(CMD_FLOW, 0, 3, '1);
        push_cmd(CMD_FLOW, 3, 0, '1);
        push_cmd(CMD_FLOW, ELEMS - 1, 5, 40'd2 << 16);
        push_cmd(CMD_FLOW, 5, ELEMS - 1, '1);
        push_cmd(CMD_FLOW, 6, 5, 40'd1 << 16);
        push_cmd(CMD_FLOW, 3, 4, 40'd1 << 16);
        push_cmd(CMD_FLOW, 4, 3, 40'd1 << 16);
        push_cmd(CMD_FLOW, 4, 5, '0);
        push_cmd(CMD_FLOW, 5, 4, 40'd3 << 16);
        push_cmd(CMD_RESTART, 0, 0, '0);
        push_cmd(CMD_SPARE, ELEMS - 1, ELEMS - 1, '1);
        push_cmd(CMD_FLOW, 5, 4, 40'd3 << 16);
        wait_drained();

        // Populate a working set, then sweep ceilings including both extremes
        for (int n = 0; n < 40; n++)
            push_random_write($urandom_range(0, ELEMS - 1));
        push_random_mix(60);
        wait_drained();

        ceilings[0] = '0;
        ceilings[1] = '1;
        ceilings[2] = 48'({$urandom(), $urandom()});
        ceilings[3] = CEILING_RESET;
        for (int p = 0; p < 4; p++)
        begin
            write_ceiling(ceilings[p]);
            if (p == 3)
                quiet = 1'b1;
            push_cmd(CMD_RESTART, 0, 0, rnd40());
            push_random_mix(95);
            wait_drained();
        end

        repeat (30) @(posedge clk);
        $display("covered %0d transactions, %0d with nonzero flow, ceilings 0 / max / random / reset",
                 n_results, n_flows);
        $display("mismatches: %0d, predictions left over: %0d", n_mismatch, flow_expect_q.size());
        if (n_mismatch == 0 && flow_expect_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/gef_pkg.sv
src/groundwater_edge_flow_top.sv
dv/tb_groundwater_edge_flow_top.sv
